### src/chained_hash_index_table_unit_assert.svh
`ifndef CHAINED_HASH_INDEX_TABLE_UNIT_ASSERT_SVH
`define CHAINED_HASH_INDEX_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CHIT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CHIT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/chit_pkg.sv
package chit_pkg;

    localparam int NUM_BUCKETS = 1024;
    localparam int POOL_NODES  = 1024;

    localparam int BKT_W   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int BC_W    = $clog2(NUM_BUCKETS + 1);
    localparam int NODE_W  = $clog2(POOL_NODES);
    localparam int FRESH_W = $clog2(POOL_NODES + 1);

    localparam int BUCKET_COUNT_W = 11;

    localparam logic REG_BUCKET_COUNT = 1'b0;
    localparam logic REG_BLOCK_ID     = 1'b1;

    localparam logic [1:0] MODE_WRITE  = 2'd0;
    localparam logic [1:0] MODE_READ   = 2'd1;
    localparam logic [1:0] MODE_DELETE = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EXISTS    = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_POOL_FULL = 3'd3;
    localparam logic [2:0] ST_BLOCK_ID  = 3'd4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] key;
        logic [31:0] data_offset;
        logic [30:0] data_size;
    } req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [31:0]        found_offset;
        logic [30:0]        found_size;
        logic signed [31:0] live_entries;
        logic [31:0]        version;
        logic [31:0]        deleted_entries;
    } rsp_t;

    typedef struct packed {
        logic [63:0]       key;
        logic [NODE_W-1:0] next;
        logic [31:0]       offset;
        logic [30:0]       size;
    } node_t;

endpackage

### src/chained_hash_index_table_unit.sv
// Keyed index table with separate chaining.
// An item is taken on a rising edge with start high and busy low; req carries
// mode (write, read, delete), key, offset and size. Exactly one result comes
// back per item on rsp, marked by done for one cycle; the receiver cannot hold
// it off, and a new item may be started in the same cycle that done is high.
// Configuration (bucket count, block id) is written through cfg_we, cfg_index
// and cfg_data while the block is idle, a rule for the user that the block
// does not enforce. The modulo unit finds the bucket; the head and each chain
// node visited are then read and checked in turn. A write or delete that
// changes the table then writes the node and relinks its predecessor or the
// bucket head, and a write that reuses a freed node first reads the free list
// head. Only one item is in work at a time: a new one waits for the last result.
// After reset the bucket head memory is cleared, one entry per cycle, over all
// NUM_BUCKETS (1024) entries; busy stays high during this pass and
// configuration writes are still taken.
module chained_hash_index_table_unit import chit_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  req_t        req,
    output logic        done,
    output rsp_t        rsp,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    typedef enum logic [9:0] {
        S_CLEAR    = 10'b0000000001,
        S_IDLE     = 10'b0000000010,
        S_HASH     = 10'b0000000100,
        S_HEAD_RD  = 10'b0000001000,
        S_HEAD_CHK = 10'b0000010000,
        S_NODE_RD  = 10'b0000100000,
        S_NODE_CHK = 10'b0001000000,
        S_DECIDE   = 10'b0010000000,
        S_FREE_CHK = 10'b0100000000,
        S_LINK     = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic   wr_node_reg, wr_node_next;

    logic [BUCKET_COUNT_W-1:0] bucket_count_reg;
    logic [31:0]               block_id_reg;

    req_t              req_reg;
    logic [BKT_W-1:0]  bucket_reg, bucket_next;
    logic [BKT_W-1:0]  clr_reg, clr_next;
    logic [NODE_W-1:0] pos_reg, pos_next;
    logic [NODE_W-1:0] prev_reg, prev_next;
    logic [NODE_W-1:0] new_reg, new_next;
    node_t             prev_word_reg, prev_word_next;
    node_t             cur_word_reg, cur_word_next;
    logic              found_reg, found_next;
    logic [NODE_W-1:0] free_head_reg, free_head_next;
    logic [FRESH_W-1:0] fresh_reg, fresh_next;

    logic [31:0] version_reg, version_next;
    logic [31:0] live_reg, live_next;
    logic [31:0] seq_reg, seq_next;
    logic [31:0] live_bytes_reg, live_bytes_next;
    logic [31:0] del_reg, del_next;
    logic [31:0] del_bytes_reg, del_bytes_next;

    logic done_reg, done_next;
    rsp_t rsp_reg, rsp_next;

    logic              b_we;
    logic [BKT_W-1:0]  b_waddr;
    logic [NODE_W-1:0] b_wdata;
    logic [NODE_W-1:0] b_rdata;
    logic              n_we;
    logic [NODE_W-1:0] n_waddr;
    node_t             n_wdata;
    logic [NODE_W-1:0] n_raddr;
    node_t             n_rdata;
    logic [NODE_W-1:0] link_target;

    logic              accept;
    logic [31:0]       bc_ext;
    logic [BC_W-1:0]   bc_eff;
    logic              mod_done;
    logic [BKT_W-1:0]  mod_rem;

    assign accept = start && (state_reg == S_IDLE);
    assign bc_ext = 32'(bucket_count_reg);

    always_comb
    begin
        if (bc_ext == 32'd0)
        begin
            bc_eff = BC_W'(1);
        end
        else if (bc_ext > 32'(NUM_BUCKETS))
        begin
            bc_eff = BC_W'(NUM_BUCKETS);
        end
        else
        begin
            bc_eff = BC_W'(bc_ext);
        end
    end

    chit_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .dividend (req.key[31:0]),
        .divisor  (bc_eff),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    chit_ram #(.WIDTH(NODE_W), .DEPTH(NUM_BUCKETS)) u_heads (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (bucket_reg),
        .rdata (b_rdata)
    );

    chit_ram #(.WIDTH($bits(node_t)), .DEPTH(POOL_NODES)) u_nodes (
        .clk   (clk),
        .we    (n_we),
        .waddr (n_waddr),
        .wdata (n_wdata),
        .raddr (n_raddr),
        .rdata (n_rdata)
    );

    // In the decision state the free list head is read in case a write pops it.
    assign n_raddr = (state_reg == S_DECIDE) ? free_head_reg : pos_reg;

    assign link_target = (req_reg.mode == MODE_WRITE) ? new_reg : cur_word_reg.next;

    always_comb
    begin
        state_next      = state_reg;
        wr_node_next    = 1'b0;
        bucket_next     = bucket_reg;
        clr_next        = clr_reg;
        pos_next        = pos_reg;
        prev_next       = prev_reg;
        new_next        = new_reg;
        prev_word_next  = prev_word_reg;
        cur_word_next   = cur_word_reg;
        found_next      = found_reg;
        free_head_next  = free_head_reg;
        fresh_next      = fresh_reg;
        version_next    = version_reg;
        live_next       = live_reg;
        seq_next        = seq_reg;
        live_bytes_next = live_bytes_reg;
        del_next        = del_reg;
        del_bytes_next  = del_bytes_reg;
        done_next       = 1'b0;
        rsp_next        = rsp_reg;
        b_we            = 1'b0;
        b_waddr         = bucket_reg;
        b_wdata         = '0;
        n_we            = 1'b0;
        n_waddr         = pos_reg;
        n_wdata         = cur_word_reg;

        // Default result: no payload, current statistics.
        if (state_reg != S_IDLE)
        begin
            rsp_next.status          = ST_OK;
            rsp_next.found_offset    = '0;
            rsp_next.found_size      = '0;
            rsp_next.live_entries    = signed'(live_reg);
            rsp_next.version         = version_reg;
            rsp_next.deleted_entries = del_reg;
        end

        case (state_reg)
            S_CLEAR:
            begin
                b_we     = 1'b1;
                b_waddr  = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == 32'(NUM_BUCKETS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (mod_done)
                begin
                    bucket_next = mod_rem;
                    state_next  = S_HEAD_RD;
                end
            end
            S_HEAD_RD:
            begin
                state_next = S_HEAD_CHK;
            end
            S_HEAD_CHK:
            begin
                pos_next   = b_rdata;
                prev_next  = '0;
                found_next = 1'b0;
                state_next = (b_rdata == '0) ? S_DECIDE : S_NODE_RD;
            end
            S_NODE_RD:
            begin
                state_next = S_NODE_CHK;
            end
            S_NODE_CHK:
            begin
                if (n_rdata.key == req_reg.key)
                begin
                    found_next    = 1'b1;
                    cur_word_next = n_rdata;
                    state_next    = S_DECIDE;
                end
                else
                begin
                    prev_next      = pos_reg;
                    prev_word_next = n_rdata;
                    pos_next       = n_rdata.next;
                    state_next     = (n_rdata.next == '0) ? S_DECIDE : S_NODE_RD;
                end
            end
            S_DECIDE:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                case (req_reg.mode)
                    MODE_WRITE:
                    begin
                        if (found_reg)
                        begin
                            rsp_next.status = ST_EXISTS;
                        end
                        else if (block_id_reg == 32'd0)
                        begin
                            rsp_next.status = ST_BLOCK_ID;
                        end
                        else if (free_head_reg != '0)
                        begin
                            done_next  = 1'b0;
                            state_next = S_FREE_CHK;
                        end
                        else if (fresh_reg < FRESH_W'(POOL_NODES))
                        begin
                            new_next     = NODE_W'(fresh_reg);
                            fresh_next   = fresh_reg + 1'b1;
                            done_next    = 1'b0;
                            wr_node_next = 1'b1;
                            state_next   = S_LINK;
                        end
                        else
                        begin
                            rsp_next.status = ST_POOL_FULL;
                        end
                    end
                    MODE_READ:
                    begin
                        if (found_reg)
                        begin
                            rsp_next.found_offset = cur_word_reg.offset;
                            rsp_next.found_size   = cur_word_reg.size;
                        end
                        else
                        begin
                            rsp_next.status = ST_NOT_FOUND;
                        end
                    end
                    MODE_DELETE:
                    begin
                        if (!found_reg)
                        begin
                            rsp_next.status = ST_NOT_FOUND;
                        end
                        else if (block_id_reg == 32'd0)
                        begin
                            rsp_next.status = ST_BLOCK_ID;
                        end
                        else
                        begin
                            done_next    = 1'b0;
                            wr_node_next = 1'b1;
                            state_next   = S_LINK;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_FREE_CHK:
            begin
                new_next       = free_head_reg;
                free_head_next = n_rdata.next;
                wr_node_next   = 1'b1;
                state_next     = S_LINK;
            end
            S_LINK:
            begin
                if (wr_node_reg)
                begin
                    // First step: write the new or freed node itself.
                    n_we = 1'b1;
                    if (req_reg.mode == MODE_WRITE)
                    begin
                        n_waddr        = new_reg;
                        n_wdata.key    = req_reg.key;
                        n_wdata.next   = '0;
                        n_wdata.offset = req_reg.data_offset;
                        n_wdata.size   = req_reg.data_size;
                    end
                    else
                    begin
                        n_waddr        = pos_reg;
                        n_wdata        = cur_word_reg;
                        n_wdata.next   = free_head_reg;
                        free_head_next = pos_reg;
                    end
                end
                else
                begin
                    // Second step: relink the predecessor or the bucket head.
                    if (prev_reg != '0)
                    begin
                        n_we         = 1'b1;
                        n_waddr      = prev_reg;
                        n_wdata      = prev_word_reg;
                        n_wdata.next = link_target;
                    end
                    else
                    begin
                        b_we    = 1'b1;
                        b_wdata = link_target;
                    end
                    version_next = version_reg + 32'd1;
                    if (req_reg.mode == MODE_WRITE)
                    begin
                        live_next       = live_reg + 32'd1;
                        seq_next        = seq_reg + 32'd1;
                        live_bytes_next = live_bytes_reg + 32'(req_reg.data_size);
                    end
                    else
                    begin
                        live_next       = live_reg - 32'd1;
                        live_bytes_next = live_bytes_reg - 32'(cur_word_reg.size);
                        del_next        = del_reg + 32'd1;
                        del_bytes_next  = del_bytes_reg + 32'(cur_word_reg.size);
                        rsp_next.found_offset = cur_word_reg.offset;
                        rsp_next.found_size   = cur_word_reg.size;
                    end
                    rsp_next.live_entries    = signed'(live_next);
                    rsp_next.version         = version_next;
                    rsp_next.deleted_entries = del_next;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            wr_node_reg      <= 1'b0;
            clr_reg          <= '0;
            bucket_count_reg <= BUCKET_COUNT_W'(1024);
            block_id_reg     <= '0;
            free_head_reg    <= '0;
            fresh_reg        <= FRESH_W'(1);
            version_reg      <= '0;
            live_reg         <= '0;
            seq_reg          <= 32'd1;
            live_bytes_reg   <= '0;
            del_reg          <= '0;
            del_bytes_reg    <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            wr_node_reg    <= wr_node_next;
            clr_reg        <= clr_next;
            free_head_reg  <= free_head_next;
            fresh_reg      <= fresh_next;
            version_reg    <= version_next;
            live_reg       <= live_next;
            seq_reg        <= seq_next;
            live_bytes_reg <= live_bytes_next;
            del_reg        <= del_next;
            del_bytes_reg  <= del_bytes_next;
            done_reg       <= done_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_BUCKET_COUNT: bucket_count_reg <= cfg_data[BUCKET_COUNT_W-1:0];
                    REG_BLOCK_ID:     block_id_reg     <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        bucket_reg    <= bucket_next;
        pos_reg       <= pos_next;
        prev_reg      <= prev_next;
        new_reg       <= new_next;
        prev_word_reg <= prev_word_next;
        cur_word_reg  <= cur_word_next;
        found_reg     <= found_next;
        rsp_reg       <= rsp_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

`include "chained_hash_index_table_unit_assert.svh"

    `CHIT_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy, "item accepted but block not busy")
    `CHIT_ASSERT_NOW(a_done_when_idle, done, !busy, "result strobe while an item is in work")
    `CHIT_ASSERT_NOW(a_fresh_bound, 1'b1, fresh_reg <= FRESH_W'(POOL_NODES), "fresh node past pool")
    `CHIT_ASSERT_NOW(a_status_legal, done, rsp.status <= ST_BLOCK_ID, "illegal status code")

endmodule

### src/chit_ram.sv
module chit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/chit_mod.sv
module chit_mod import chit_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [31:0]      dividend,
    input  logic [BC_W-1:0]  divisor,
    output logic             done,
    output logic [BKT_W-1:0] rem
);

    // Restoring remainder, four dividend bits per cycle, over all 32 dividend bits.
    logic            run_reg, run_next;
    logic [2:0]      cnt_reg, cnt_next;
    logic            done_reg, done_next;
    logic [31:0]     quo_reg, quo_next;
    logic [BC_W-1:0] rem_reg, rem_next;

    logic [BC_W-1:0] r;
    logic [31:0]     d;
    logic [BC_W:0]   t;

    always_comb
    begin
        r = rem_reg;
        d = quo_reg;
        t = '0;
        for (int i = 0; i < 4; i++)
        begin
            t = {r, d[31]};
            d = {d[30:0], 1'b0};
            if (t >= {1'b0, divisor})
            begin
                t = t - {1'b0, divisor};
            end
            r = t[BC_W-1:0];
        end
    end

    always_comb
    begin
        run_next  = run_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            quo_next = dividend;
            rem_next = '0;
        end
        else if (run_reg)
        begin
            quo_next = d;
            rem_next = r;
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'd7)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg[BKT_W-1:0];

endmodule

### bench/chit_checker.sv
module chit_checker import chit_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  req_t        req,
    input  logic        done,
    input  rsp_t        rsp,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          results_pending
);

    logic [10:0]        bucket_cfg;
    logic [31:0]        block_cfg;
    logic [NODE_W-1:0]  chain_head [NUM_BUCKETS];
    logic [63:0]        node_key [POOL_NODES];
    logic [NODE_W-1:0]  node_link [POOL_NODES];
    logic [31:0]        node_off [POOL_NODES];
    logic [30:0]        node_size [POOL_NODES];
    int                 free_top;
    int                 fresh_node;
    logic [31:0]        version_cnt;
    logic [31:0]        live_cnt;
    logic [31:0]        live_bytes;
    logic [31:0]        del_cnt;
    logic [31:0]        del_bytes;
    rsp_t               expected_results [$];

    assign results_pending = expected_results.size();

    function automatic int bucket_index(input logic [63:0] k);
        int bc;
        bc = bucket_cfg;
        if (bc == 0) bc = 1;
        if (bc > NUM_BUCKETS) bc = NUM_BUCKETS;
        return int'(k[31:0] % bc);
    endfunction

    // On a hit, node is the match and prv the node before it; on a miss prv is
    // the chain tail. Zero means none.
    function automatic bit lookup_chain(input logic [63:0] k, output int node,
                                        output int prv);
        int pos;
        int steps;
        pos = chain_head[bucket_index(k)];
        steps = 0;
        node = 0;
        prv = 0;
        while (pos != 0 && steps < POOL_NODES) begin
            if (node_key[pos] == k) begin
                node = pos;
                return 1'b1;
            end
            prv = pos;
            pos = node_link[pos];
            steps++;
        end
        return 1'b0;
    endfunction

    function automatic rsp_t apply_index_op(input req_t r);
        rsp_t res;
        int   node;
        int   prv;
        int   slot;
        bit   hit;
        res = '0;
        res.status = ST_OK;
        hit = lookup_chain(r.key, node, prv);
        if (r.mode == MODE_WRITE) begin
            if (hit) begin
                res.status = ST_EXISTS;
            end else if (block_cfg == 0) begin
                res.status = ST_BLOCK_ID;
            end else begin
                slot = 0;
                if (free_top != 0) begin
                    slot = free_top;
                    free_top = node_link[slot];
                end else if (fresh_node < POOL_NODES) begin
                    slot = fresh_node;
                    fresh_node++;
                end
                if (slot == 0) begin
                    res.status = ST_POOL_FULL;
                end else begin
                    node_key[slot] = r.key;
                    node_link[slot] = '0;
                    node_off[slot] = r.data_offset;
                    node_size[slot] = r.data_size;
                    if (prv != 0) node_link[prv] = NODE_W'(slot);
                    else chain_head[bucket_index(r.key)] = NODE_W'(slot);
                    version_cnt++;
                    live_cnt++;
                    live_bytes += 32'(r.data_size);
                end
            end
        end else if (r.mode == MODE_READ) begin
            if (hit) begin
                res.found_offset = node_off[node];
                res.found_size = node_size[node];
            end else begin
                res.status = ST_NOT_FOUND;
            end
        end else if (r.mode == MODE_DELETE) begin
            if (!hit) begin
                res.status = ST_NOT_FOUND;
            end else if (block_cfg == 0) begin
                res.status = ST_BLOCK_ID;
            end else begin
                res.found_offset = node_off[node];
                res.found_size = node_size[node];
                if (prv != 0) node_link[prv] = node_link[node];
                else chain_head[bucket_index(r.key)] = node_link[node];
                version_cnt++;
                live_cnt--;
                live_bytes -= 32'(node_size[node]);
                del_cnt++;
                del_bytes += 32'(node_size[node]);
                node_link[node] = NODE_W'(free_top);
                free_top = node;
            end
        end
        res.live_entries = live_cnt;
        res.version = version_cnt;
        res.deleted_entries = del_cnt;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        rsp_t want;
        if (!rst_n) begin
            bucket_cfg <= 11'd1024;
            block_cfg <= '0;
            for (int i = 0; i < NUM_BUCKETS; i++) chain_head[i] = '0;
            free_top = 0;
            fresh_node = 1;
            version_cnt = '0;
            live_cnt = '0;
            live_bytes = '0;
            del_cnt = '0;
            del_bytes = '0;
            fail_count <= 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_BUCKET_COUNT) bucket_cfg <= cfg_data[10:0];
                else block_cfg <= cfg_data;
            end
            if (done) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with nothing expected: %h", $time, rsp);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (rsp !== want) begin
                        if (rsp.status !== want.status)
                            $display("%0t: status expected %0d actual %0d",
                                     $time, want.status, rsp.status);
                        if (rsp.found_offset !== want.found_offset)
                            $display("%0t: found_offset expected %h actual %h",
                                     $time, want.found_offset, rsp.found_offset);
                        if (rsp.found_size !== want.found_size)
                            $display("%0t: found_size expected %h actual %h",
                                     $time, want.found_size, rsp.found_size);
                        if (rsp.live_entries !== want.live_entries)
                            $display("%0t: live_entries expected %0d actual %0d",
                                     $time, want.live_entries, rsp.live_entries);
                        if (rsp.version !== want.version)
                            $display("%0t: version expected %0d actual %0d",
                                     $time, want.version, rsp.version);
                        if (rsp.deleted_entries !== want.deleted_entries)
                            $display("%0t: deleted_entries expected %0d actual %0d",
                                     $time, want.deleted_entries, rsp.deleted_entries);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy) expected_results.push_back(apply_index_op(req));
        end
    end

endmodule

### bench/tb_top.sv
module tb_top;
    import chit_pkg::*;

    localparam logic [1:0] MODE_NOP = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    req_t        req;
    logic        done;
    rsp_t        rsp;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_data;
    int          fail_count;
    int          results_pending;
    bit          allow_idle;
    logic [63:0] key_pool [32];

    chained_hash_index_table_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    chit_checker u_chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .fail_count(fail_count),
        .results_pending(results_pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #200000000;
        $display("[chained_hash_index_table_unit] ERROR");
        $finish;
    end

    task automatic write_reg(input logic idx, input logic [31:0] val);
        @(negedge clk);
        start <= 1'b0;
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Item is held from a falling edge until a rising edge sees busy low.
    task automatic send_item(input logic [1:0] m, input logic [63:0] k,
                             input logic [31:0] off, input logic [30:0] sz);
        if (allow_idle && $urandom_range(0, 3) == 0) begin
            @(negedge clk);
            start <= 1'b0;
            repeat ($urandom_range(0, 9)) @(negedge clk);
        end else begin
            @(negedge clk);
        end
        start <= 1'b1;
        req <= '{mode: m, key: k, data_offset: off, data_size: sz};
        while (busy) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic send_random(input logic [1:0] m, input logic [63:0] k);
        send_item(m, k, $urandom, 31'($urandom));
    endtask

    task automatic drain;
        @(negedge clk);
        start <= 1'b0;
        while (results_pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    function automatic logic [1:0] pick_mode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return MODE_WRITE;
        if (r < 70) return MODE_READ;
        if (r < 95) return MODE_DELETE;
        return MODE_NOP;
    endfunction

    initial begin
        logic [63:0] k0, k1, k2;
        logic [31:0] fill_tag;
        int          bucket_set [8];
        logic [63:0] k;
        start = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_index = REG_BUCKET_COUNT;
        cfg_data = '0;
        allow_idle = 1'b1;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Block id zero rejects a write; read and delete miss.
        k0 = 64'd0;
        k1 = '1;
        k2 = 64'h8000_0000_0000_0000;
        send_item(MODE_WRITE, k0, '1, '1);
        send_item(MODE_READ, k0, '0, '0);
        send_item(MODE_DELETE, k0, '0, '0);
        drain();

        // A bucket count of zero acts as one, so everything shares one chain.
        write_reg(REG_BUCKET_COUNT, 32'd0);
        write_reg(REG_BLOCK_ID, '1);
        send_item(MODE_WRITE, k0, '1, '1);
        send_item(MODE_WRITE, k1, 32'h1234_5678, 31'h0555_aaaa);
        send_item(MODE_WRITE, k2, '0, '0);
        send_item(MODE_WRITE, k1, '0, '0);
        send_item(MODE_READ, k2, '0, '0);
        send_item(MODE_READ, 64'h55, '0, '0);
        send_item(MODE_DELETE, k1, '0, '0);
        send_item(MODE_READ, k1, '0, '0);
        send_item(MODE_DELETE, k0, '0, '0);
        send_item(MODE_DELETE, k2, '0, '0);
        send_item(MODE_WRITE, k1, 32'hdead_beef, 31'h7fff_0001);
        send_item(MODE_WRITE, k0, 32'h0f0f_0f0f, 31'h1);
        send_item(MODE_NOP, k1, '1, '1);
        drain();
        write_reg(REG_BLOCK_ID, 32'd0);
        write_reg(REG_BUCKET_COUNT, 32'd2047);
        send_item(MODE_WRITE, k2, '1, '1);
        send_item(MODE_WRITE, k1, '1, '1);
        send_item(MODE_DELETE, k1, '0, '0);
        send_item(MODE_DELETE, 64'h77, '0, '0);
        send_item(MODE_READ, k1, '0, '0);
        drain();

        bucket_set = '{1, 2, 7, 1024, 2047, 0, 500, 0};
        bucket_set[7] = $urandom_range(1, 1024);
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(REG_BUCKET_COUNT, 32'(bucket_set[ph]));
            write_reg(REG_BLOCK_ID, (ph == 5) ? 32'd0 : (ph == 2) ? '1 : $urandom | 32'd1);
            for (int i = 0; i < 32; i++) key_pool[i] = {$urandom, $urandom};
            for (int i = 0; i < 70; i++) begin
                k = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                                : key_pool[$urandom_range(0, 31)];
                send_random(pick_mode(), k);
            end
            drain();
        end

        // Fill the pool until writes report it full, one node per bucket mostly.
        write_reg(REG_BUCKET_COUNT, 32'd1024);
        write_reg(REG_BLOCK_ID, $urandom | 32'd1);
        fill_tag = $urandom;
        for (int i = 0; i < 1060; i++)
            send_random(MODE_WRITE, {fill_tag ^ 32'(i * 7), 32'(i)});

        allow_idle = 1'b0;
        for (int i = 0; i < 120; i++) begin
            k = $urandom_range(0, 1059);
            send_random(pick_mode(), {fill_tag ^ 32'(k * 7), k[31:0]});
        end

        @(negedge clk);
        start <= 1'b0;
        while (results_pending != 0) @(negedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("[chained_hash_index_table_unit] OK");
        else
            $display("[chained_hash_index_table_unit] ERROR");
        $finish;
    end

endmodule

### chained_hash_index_table_unit.f
+incdir+src
src/chit_pkg.sv
src/chit_ram.sv
src/chit_mod.sv
src/chained_hash_index_table_unit.sv
bench/chit_checker.sv
bench/tb_top.sv
